[sv/heater_safety_thermostat_macros.svh]
// assertion macros for the heater safety thermostat
`ifndef HEATER_SAFETY_THERMOSTAT_MACROS_SVH
`define HEATER_SAFETY_THERMOSTAT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define HST_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("heater thermostat check failed");

// condition must hold in the cycle after the trigger
`define HST_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("heater thermostat check failed");

`endif

[sv/hst_pkg.sv]
// types, codes and constants shared by the heater thermostat files
package hst_pkg;

  localparam int WATCHDOG_SECONDS_DEF = 5;
  localparam int OTP_MARGIN           = 640;
  localparam int REACHED_MARGIN       = 128;
  localparam int WD_LEFT_MAX          = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // fault flag bit positions
  localparam int FLAG_SENSOR    = 0;
  localparam int FLAG_MAXTEMP   = 1;
  localparam int FLAG_PROTECT   = 2;
  localparam int FLAG_WATCHDOG  = 3;
  localparam int FLAG_EMERGENCY = 4;
  localparam int FLAG_W         = 5;

  typedef enum logic [2:0] {
    OP_CONTROL = 3'd0,
    OP_TICK    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_ESTOP   = 3'd3,
    OP_EXT_OT  = 3'd4
  } hst_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 2'd0,
    REG_HYSTERESIS = 2'd1,
    REG_REGULATION = 2'd2,
    REG_BOIL       = 2'd3
  } hst_reg_t;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [15:0] heater_temp_a;
    logic signed [15:0] heater_temp_b;
    logic signed [15:0] fluid_temp;
    logic        [2:0]  sensor_fault_bits;
    logic               protect_pin;
  } hst_in_t;

  typedef struct packed {
    logic              heater_on;
    logic [FLAG_W-1:0] fault_flags;
    logic              temp_reached;
    logic [2:0]        watchdog_left;
  } hst_out_t;

  typedef struct packed {
    logic signed [15:0] target_temp;
    logic        [14:0] hysteresis;
    logic               regulation_on;
    logic        [12:0] boil_temp;
  } hst_cfg_t;

endpackage

[sv/hst_stream_if.sv]
// valid/ready stream channel carrying one word of a given payload type
interface hst_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/hst_cfg_regs.sv]
// configuration register file written through the plain write port
module hst_cfg_regs import hst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output hst_cfg_t              cfg
);

  hst_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (hst_reg_t'(cfg_idx))
        REG_TARGET:     cfg_nxt.target_temp   = cfg_wdata;
        REG_HYSTERESIS: cfg_nxt.hysteresis    = cfg_wdata[14:0];
        REG_REGULATION: cfg_nxt.regulation_on = cfg_wdata[0];
        REG_BOIL:       cfg_nxt.boil_temp     = cfg_wdata[12:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/hst_core.sv]
// fault flags, watchdog and hysteresis thermostat with their state registers
module hst_core import hst_pkg::*; #(
  parameter int WATCHDOG_SECONDS = WATCHDOG_SECONDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  hst_in_t  item,
  input  hst_cfg_t cfg,
  output hst_out_t result
);

  localparam int WdW = $clog2(WATCHDOG_SECONDS + 1);

  logic [FLAG_W-1:0] fault_r, fault_nxt;
  logic              heater_r, heater_nxt;
  logic [WdW-1:0]    wd_r, wd_nxt;

  logic signed [16:0] ta, tb, tf, hot, tgt, low, hyst_s, boil_s, limit, reach_lim;
  logic [FLAG_W-1:0]  chk, raise;

  assign ta        = {item.heater_temp_a[15], item.heater_temp_a};
  assign tb        = {item.heater_temp_b[15], item.heater_temp_b};
  assign tf        = {item.fluid_temp[15], item.fluid_temp};
  assign tgt       = {cfg.target_temp[15], cfg.target_temp};
  assign hyst_s    = {2'b00, cfg.hysteresis};
  assign boil_s    = {4'b0000, cfg.boil_temp};
  assign limit     = boil_s + 17'(OTP_MARGIN);
  assign reach_lim = boil_s - 17'(REACHED_MARGIN);
  assign low       = tgt - hyst_s;
  assign hot       = (tb > ta) ? tb : ta;

  // sensor fault masks the limit and pin checks
  always_comb begin
    chk = '0;
    if (item.sensor_fault_bits != 3'd0) begin
      chk[FLAG_SENSOR] = 1'b1;
    end else begin
      chk[FLAG_MAXTEMP] = (ta >= limit) || (tb >= limit);
      chk[FLAG_PROTECT] = item.protect_pin;
    end
  end

  always_comb begin
    fault_nxt  = fault_r;
    heater_nxt = heater_r;
    wd_nxt     = wd_r;
    raise      = '0;
    case (hst_op_t'(item.op))
      OP_CONTROL: begin
        raise = chk;
        if ((fault_r | chk) == '0) begin
          wd_nxt = WdW'(WATCHDOG_SECONDS);
          if (cfg.regulation_on) begin
            if (hot >= tgt) begin
              heater_nxt = 1'b0;
            end else if (hot < low) begin
              heater_nxt = 1'b1;
            end
          end
        end
      end
      OP_TICK: begin
        if (wd_r != '0) begin
          wd_nxt = wd_r - WdW'(1);
        end else begin
          raise[FLAG_WATCHDOG] = 1'b1;
        end
      end
      OP_CLEAR: begin
        fault_nxt = '0;
        raise     = chk;
      end
      OP_ESTOP:  raise[FLAG_EMERGENCY] = 1'b1;
      OP_EXT_OT: raise[FLAG_PROTECT]   = 1'b1;
      default: ;
    endcase
    fault_nxt = fault_nxt | raise;
    if (raise != '0) begin
      heater_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r  <= '0;
      heater_r <= 1'b0;
      wd_r     <= WdW'(WATCHDOG_SECONDS);
    end else if (fire) begin
      fault_r  <= fault_nxt;
      heater_r <= heater_nxt;
      wd_r     <= wd_nxt;
    end
  end

  always_comb begin
    result.heater_on    = heater_nxt;
    result.fault_flags  = fault_nxt;
    result.temp_reached = (item.sensor_fault_bits == 3'd0) && (tf >= reach_lim);
    if (32'(wd_nxt) > 32'(WD_LEFT_MAX)) begin
      result.watchdog_left = 3'(WD_LEFT_MAX);
    end else begin
      result.watchdog_left = 3'(wd_nxt);
    end
  end

endmodule

[sv/heater_safety_thermostat.sv]
// Heater safety thermostat: takes one word per clock unless out_s stalls it and
// returns exactly one result word per input word. Each word passes an input
// register, then the flag, watchdog and thermostat logic updates the state and
// fills the result register, from which the result word is offered on out_s;
// with out_s.ready held high the block sustains one word per cycle.
// Configuration writes act on the next cycle and should be made while the block
// holds no word. After reset the flags are clear, the heater is off and the
// watchdog holds WATCHDOG_SECONDS.
`include "heater_safety_thermostat_macros.svh"

module heater_safety_thermostat import hst_pkg::*; #(
  parameter int WATCHDOG_SECONDS = WATCHDOG_SECONDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hst_stream_if.sink            in_s,
  hst_stream_if.source          out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WdLeftBound = (WATCHDOG_SECONDS > WD_LEFT_MAX) ? WD_LEFT_MAX :
                               WATCHDOG_SECONDS;

  hst_cfg_t cfg;
  hst_out_t core_res;

  logic     s1_valid_r, s1_valid_nxt;
  hst_in_t  s1_item_r;
  logic     out_valid_r, out_valid_nxt;
  hst_out_t out_data_r;
  logic     out_load, in_fire;

  hst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hst_core #(
    .WATCHDOG_SECONDS (WATCHDOG_SECONDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (out_load),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  // the held word moves on whenever the result register is free or draining
  assign out_load   = s1_valid_r && (!out_valid_r || out_s.ready);
  assign in_s.ready = !s1_valid_r || out_load;
  assign in_fire    = in_s.valid && in_s.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_s.data;
    end
    if (out_load) begin
      out_data_r <= core_res;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

  `HST_ASSERT_SAME(a_flag_forces_off, clk, rst_n,
    out_valid_r && (out_data_r.fault_flags != '0), !out_data_r.heater_on)
  `HST_ASSERT_SAME(a_full_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_s.ready, !in_s.ready)
  `HST_ASSERT_SAME(a_watchdog_bound, clk, rst_n,
    out_valid_r, 32'(out_data_r.watchdog_left) <= 32'(WdLeftBound))
  `HST_ASSERT_NEXT(a_load_shows_word, clk, rst_n, out_load, out_valid_r)

endmodule

[sim/heater_safety_thermostat_tb.sv]
// self-checking testbench for the heater safety thermostat
`timescale 1ns / 100ps

module heater_safety_thermostat_tb import hst_pkg::*; ();

  localparam int WD_SECONDS   = WATCHDOG_SECONDS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_WORDS  = 150;

  class thermostat_scoreboard;
    logic signed [15:0] target_temp;
    logic [14:0]        hysteresis;
    logic               regulation_on;
    logic [12:0]        boil_temp;
    logic [FLAG_W-1:0]  flags;
    logic               heater;
    int unsigned        wd_count;
    hst_out_t           pending_outputs[$];
    logic [FLAG_W-1:0]  flags_seen;
    int                 heater_starts;
    int                 failures;
    int                 checked;

    function new();
      target_temp   = '0;
      hysteresis    = '0;
      regulation_on = 1'b0;
      boil_temp     = '0;
      flags         = '0;
      heater        = 1'b0;
      wd_count      = WD_SECONDS;
      flags_seen    = '0;
      heater_starts = 0;
      failures      = 0;
      checked       = 0;
    endfunction

    function void write_reg(hst_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_TARGET:     target_temp   = value;
        REG_HYSTERESIS: hysteresis    = value[14:0];
        REG_REGULATION: regulation_on = value[0];
        REG_BOIL:       boil_temp     = value[12:0];
        default: ;
      endcase
    endfunction

    function void trip(int pos);
      flags[pos] = 1'b1;
      heater     = 1'b0;
    endfunction

    // sensor, over-temperature and pin checks; true when no flag is up
    function bit checks_pass(hst_in_t w);
      int limit;
      int ta;
      int tb;
      limit = int'(boil_temp) + OTP_MARGIN;
      ta    = $signed(w.heater_temp_a);
      tb    = $signed(w.heater_temp_b);
      if (w.sensor_fault_bits != 3'd0) begin
        trip(FLAG_SENSOR);
        return 1'b0;
      end
      if (ta >= limit) trip(FLAG_MAXTEMP);
      if (tb >= limit) trip(FLAG_MAXTEMP);
      if (w.protect_pin) trip(FLAG_PROTECT);
      return flags == '0;
    endfunction

    function void accept_word(hst_in_t w);
      int       ta;
      int       tb;
      int       tf;
      int       hot;
      int       band_low;
      logic     was_on;
      hst_out_t r;
      ta     = $signed(w.heater_temp_a);
      tb     = $signed(w.heater_temp_b);
      tf     = $signed(w.fluid_temp);
      was_on = heater;
      case (w.op)
        OP_CONTROL: begin
          if (checks_pass(w)) begin
            wd_count = WD_SECONDS;
            if (regulation_on) begin
              hot      = (tb > ta) ? tb : ta;
              band_low = int'(target_temp) - int'(hysteresis);
              if (hot >= int'(target_temp)) heater = 1'b0;
              else if (hot < band_low) heater = (flags == '0);
            end
          end
        end
        OP_TICK: begin
          if (wd_count != 0) wd_count--;
          else trip(FLAG_WATCHDOG);
        end
        OP_CLEAR: begin
          flags = '0;
          void'(checks_pass(w));
        end
        OP_ESTOP:  trip(FLAG_EMERGENCY);
        OP_EXT_OT: trip(FLAG_PROTECT);
        default: ;
      endcase
      if (heater && !was_on) heater_starts++;
      flags_seen      |= flags;
      r.heater_on     = heater;
      r.fault_flags   = flags;
      r.temp_reached  = (w.sensor_fault_bits == 3'd0) &&
                        (tf >= int'(boil_temp) - REACHED_MARGIN);
      r.watchdog_left = (wd_count > WD_LEFT_MAX) ? 3'(WD_LEFT_MAX) : wd_count[2:0];
      pending_outputs.push_back(r);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(hst_out_t got);
      hst_out_t want;
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("tb: result %h arrived with nothing outstanding", got));
        return;
      end
      want = pending_outputs.pop_front();
      checked++;
      if (got.heater_on !== want.heater_on || got.fault_flags !== want.fault_flags ||
          got.temp_reached !== want.temp_reached ||
          got.watchdog_left !== want.watchdog_left)
        note_failure($sformatf(
          "tb: result %0d: heater %b/%b flags %b/%b reached %b/%b watchdog %0d/%0d (exp/got)",
          checked, want.heater_on, got.heater_on, want.fault_flags, got.fault_flags,
          want.temp_reached, got.temp_reached, want.watchdog_left, got.watchdog_left));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hst_stream_if #(.data_t(hst_in_t))  in_ch ();
  hst_stream_if #(.data_t(hst_out_t)) out_ch ();

  heater_safety_thermostat #(
    .WATCHDOG_SECONDS(WD_SECONDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  thermostat_scoreboard sb;
  int cycles;
  int words_sent;
  int settings_used;
  bit in_burst;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: timed out after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // note the input first so a same-edge result still finds its expectation
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.accept_word(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // result side: random stalls, with runs of 40 words held ready now and then
  initial begin
    int  n;
    int  stall;
    bit  out_burst;
    n = 0;
    out_burst = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (n % 40 == 0) out_burst = ($urandom_range(0, 3) == 0);
      stall = out_burst ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n++;
    end
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] around(int centre, int span);
    return sat16(centre + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic hst_in_t mk(logic [2:0] op, int ta, int tb, int tf,
                                 logic [2:0] sbits, logic pin);
    hst_in_t w;
    w.op                = op;
    w.heater_temp_a     = sat16(ta);
    w.heater_temp_b     = sat16(tb);
    w.fluid_temp        = sat16(tf);
    w.sensor_fault_bits = sbits;
    w.protect_pin       = pin;
    return w;
  endfunction

  // mostly near the thermostat band, some near the over-temperature limit
  function automatic logic signed [15:0] heater_reading();
    int m;
    m = $urandom_range(0, 9);
    if (m < 6) return around(int'(sb.target_temp), int'(sb.hysteresis) + 48);
    if (m < 8) return around(int'(sb.boil_temp) + OTP_MARGIN, 16);
    return 16'($urandom);
  endfunction

  function automatic hst_in_t next_random_word();
    hst_in_t w;
    int      pick;
    w    = hst_in_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 70 || (pick >= 70 && pick < 85)) begin
      w.heater_temp_a = heater_reading();
      w.heater_temp_b = heater_reading();
      if ($urandom_range(0, 1) == 1)
        w.fluid_temp = around(int'(sb.boil_temp) - REACHED_MARGIN, 8);
    end
    if (pick < 55) begin
      w.op                = OP_CONTROL;
      w.sensor_fault_bits = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'd0;
      w.protect_pin       = ($urandom_range(0, 19) == 0);
    end else if (pick < 70) begin
      w.op = OP_TICK;
    end else if (pick < 85) begin
      w.op                = OP_CLEAR;
      w.sensor_fault_bits = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd0;
      w.protect_pin       = ($urandom_range(0, 9) == 0);
    end else if (pick < 90) begin
      w.op = OP_ESTOP;
    end else if (pick < 95) begin
      w.op = OP_EXT_OT;
    end else if (pick < 98) begin
      w.op = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  task automatic send_word(hst_in_t w);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_outputs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(hst_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(logic signed [15:0] tgt, logic [14:0] hyst, logic reg_on,
                                logic [12:0] boil);
    drain_results();
    write_reg(REG_TARGET, tgt);
    write_reg(REG_HYSTERESIS, {1'b0, hyst});
    write_reg(REG_REGULATION, {15'd0, reg_on});
    write_reg(REG_BOIL, {3'd0, boil});
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    settings_used++;
  endtask

  initial begin
    int       p;
    int       i;
    hst_in_t  directed[$];
    sb            = new();
    cycles        = 0;
    words_sent    = 0;
    settings_used = 0;
    in_burst      = 1'b0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fluid threshold sits at minus eight degrees
    send_word(mk(OP_CONTROL, 0, 0, -128, 3'd0, 1'b0));
    send_word(mk(OP_CONTROL, 0, 0, -129, 3'd0, 1'b0));

    // target 50 C, 2 C band, boil 180 C: limit 3520, fluid threshold 2752
    apply_settings(16'sd800, 15'd32, 1'b1, 13'd2880);
    directed.push_back(mk(OP_CONTROL, 100, 200, 2752, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, 800, 0, 2751, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, 768, 700, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, 767, 0, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, 799, 799, 0, 3'd0, 1'b0));
    // count the watchdog out, then one tick past zero
    repeat (6) directed.push_back(mk(OP_TICK, 0, 0, 3000, 3'd0, 1'b0));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, 0, 0, 0, 3'd0, 1'b0));
    // sensor fault hides the limit and pin checks
    directed.push_back(mk(OP_CONTROL, 3520, 3520, 0, 3'd1, 1'b1));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 3'd4, 1'b0));
    directed.push_back(mk(OP_CLEAR, 3519, 3520, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 3'd0, 1'b1));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_CONTROL, -32768, 32767, -32768, 3'd0, 1'b0));
    directed.push_back(mk(OP_ESTOP, 0, 0, 0, 3'd0, 1'b0));
    directed.push_back(mk(OP_EXT_OT, 0, 0, 0, 3'd0, 1'b0));
    directed.push_back(mk(3'd7, -1, -1, -1, 3'd7, 1'b1));
    directed.push_back(mk(OP_CLEAR, 0, 0, 32767, 3'd0, 1'b0));
    directed.push_back(mk(3'd5, 0, 0, 0, 3'd0, 1'b0));
    foreach (directed[k]) send_word(directed[k]);

    for (p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(16'sd800, 15'd32, 1'b1, 13'd2880);
        1: apply_settings(-16'sd32768, 15'd32767, 1'b1, 13'd0);
        2: apply_settings(16'sd32767, 15'd0, 1'b1, 13'd8000);
        3: apply_settings(16'($urandom), 15'($urandom), 1'b0, 13'($urandom_range(0, 8000)));
        default: apply_settings(around(800, 600), 15'($urandom_range(0, 200)), 1'b1,
                                13'($urandom_range(0, 8000)));
      endcase
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
        if (i == PHASE_WORDS / 2) drain_results();
        send_word(next_random_word());
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_outputs.size() != 0);
    repeat (10) @(posedge clk);
    if (sb.pending_outputs.size() != 0)
      sb.note_failure($sformatf("tb: %0d results never arrived",
                                sb.pending_outputs.size()));

    $display("tb: %0d words over %0d settings, %0d results checked, %0d mismatches",
             words_sent, settings_used, sb.checked, sb.failures);
    $display("tb: flags raised %b, heater switched on %0d times",
             sb.flags_seen, sb.heater_starts);
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
